// File: rtl/pooled_linked_deque_core_assert.svh
// Assertion macros used by the deque RTL.
`ifndef POOLED_LINKED_DEQUE_CORE_ASSERT_SVH
`define POOLED_LINKED_DEQUE_CORE_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define PLD_ASSERT_SAME(lbl, clk_s, rstn_s, cond, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (cons)) \
        else $error("deque assertion failed");

// The condition implies the consequence in the next cycle.
`define PLD_ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: rtl/pld_pkg.sv
`default_nettype none

package pld_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((KIND_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + STATUS_W + 7) / 8) * 8;

    typedef logic [LINK_W-1:0]   link_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam link_t NULL_LINK = LINK_W'(POOL_DEPTH);

    localparam kind_t KIND_PUSH_FRONT = 3'd0;
    localparam kind_t KIND_PUSH_BACK  = 3'd1;
    localparam kind_t KIND_POP_FRONT  = 3'd2;
    localparam kind_t KIND_POP_BACK   = 3'd3;
    localparam kind_t KIND_PEEK_FRONT = 3'd4;
    localparam kind_t KIND_PEEK_BACK  = 3'd5;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/pooled_linked_deque_core.sv
// Channel  Direction  Signals                     Contents
// s        in         s_tvalid s_tready s_tdata   kind, push_word
// m        out        m_tvalid m_tready m_tdata   read_word, status
//
// Takes one item per cycle unless m_tready stalls; its result is then registered.
// The pool links, free list and end pointers are flip-flops updated as the item
// leaves the input register, so each item sees the effect of all earlier ones.
// Reset empties the deque and chains all nodes onto the free list at once.
// A stall on m_tready holds the result register and then the input register.
`default_nettype none
`include "pooled_linked_deque_core_assert.svh"

module pooled_linked_deque_core
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // kind [2:0], push_word [34:3], zero padding above
    input  wire  [pld_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // read_word [31:0], status [33:32], zero padding above
    output logic [pld_pkg::M_TDATA_W-1:0] m_tdata
);

    import pld_pkg::*;

    logic    in_valid_reg, in_valid_next;
    kind_t   in_kind_reg;
    word_t   in_word_reg;

    logic    out_valid_reg, out_valid_next;
    word_t   out_word_reg;
    status_t out_status_reg;

    word_t   node_word_reg [POOL_DEPTH];
    link_t   node_next_reg [POOL_DEPTH];
    link_t   node_prev_reg [POOL_DEPTH];
    link_t   free_link_reg [POOL_DEPTH];
    link_t   front_reg, front_next;
    link_t   back_reg, back_next;
    link_t   free_top_reg, free_top_next;

    logic    advance, fire, in_take;
    logic    empty, full, is_push, is_pop, take, give;
    logic    end_front, end_valid;
    link_t   end_link;
    idx_t    n_idx, e_idx, f_idx, b_idx;
    word_t   end_word;
    link_t   front_succ, back_pred;

    logic    nx_b_en, pv_b_en;
    idx_t    nx_b_idx, pv_b_idx;
    link_t   nx_b_val, pv_b_val;
    link_t   nx_a_val, pv_a_val;
    word_t   rd_word;
    status_t rd_status;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    assign empty = !(front_reg < NULL_LINK);
    assign full  = !(free_top_reg < NULL_LINK);

    assign n_idx = free_top_reg[IDX_W-1:0];
    assign f_idx = front_reg[IDX_W-1:0];
    assign b_idx = back_reg[IDX_W-1:0];

    assign end_front  = (in_kind_reg == KIND_POP_FRONT) || (in_kind_reg == KIND_PEEK_FRONT);
    assign end_link   = end_front ? front_reg : back_reg;
    assign end_valid  = end_link < NULL_LINK;
    assign e_idx      = end_link[IDX_W-1:0];
    assign end_word   = node_word_reg[e_idx];
    assign front_succ = node_next_reg[f_idx];
    assign back_pred  = node_prev_reg[b_idx];

    assign is_push = (in_kind_reg == KIND_PUSH_FRONT) || (in_kind_reg == KIND_PUSH_BACK);
    assign is_pop  = (in_kind_reg == KIND_POP_FRONT) || (in_kind_reg == KIND_POP_BACK);
    assign take    = is_push && !full;
    assign give    = is_pop && end_valid;

    always_comb
    begin
        front_next    = front_reg;
        back_next     = back_reg;
        free_top_next = free_top_reg;
        nx_a_val      = NULL_LINK;
        pv_a_val      = NULL_LINK;
        nx_b_en       = 1'b0;
        nx_b_idx      = b_idx;
        nx_b_val      = NULL_LINK;
        pv_b_en       = 1'b0;
        pv_b_idx      = f_idx;
        pv_b_val      = NULL_LINK;
        rd_word       = '0;
        rd_status     = STATUS_OK;
        unique case (in_kind_reg)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    rd_status = STATUS_FULL;
                end
                else
                begin
                    free_top_next = free_link_reg[n_idx];
                    if (empty)
                    begin
                        front_next = free_top_reg;
                        back_next  = free_top_reg;
                    end
                    else if (in_kind_reg == KIND_PUSH_FRONT)
                    begin
                        nx_a_val   = front_reg;
                        pv_b_en    = 1'b1;
                        pv_b_val   = free_top_reg;
                        front_next = free_top_reg;
                    end
                    else
                    begin
                        pv_a_val  = back_reg;
                        nx_b_en   = 1'b1;
                        nx_b_val  = free_top_reg;
                        back_next = free_top_reg;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (!end_valid)
                begin
                    rd_status = STATUS_EMPTY;
                end
                else
                begin
                    rd_word       = end_word;
                    free_top_next = end_link;
                    if (in_kind_reg == KIND_POP_FRONT)
                    begin
                        if (front_succ < NULL_LINK)
                        begin
                            front_next = front_succ;
                            pv_b_en    = 1'b1;
                            pv_b_idx   = front_succ[IDX_W-1:0];
                        end
                        else
                        begin
                            front_next = NULL_LINK;
                            back_next  = NULL_LINK;
                        end
                    end
                    else
                    begin
                        if (back_pred < NULL_LINK)
                        begin
                            back_next = back_pred;
                            nx_b_en   = 1'b1;
                            nx_b_idx  = back_pred[IDX_W-1:0];
                        end
                        else
                        begin
                            front_next = NULL_LINK;
                            back_next  = NULL_LINK;
                        end
                    end
                end
            end
            KIND_PEEK_FRONT, KIND_PEEK_BACK:
            begin
                if (end_valid)
                begin
                    rd_word = end_word;
                end
                else
                begin
                    rd_status = STATUS_EMPTY;
                end
            end
            default:
            begin
                rd_status = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            front_reg     <= NULL_LINK;
            back_reg      <= NULL_LINK;
            free_top_reg  <= '0;
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                free_link_reg[i] <= (i == POOL_DEPTH - 1) ? NULL_LINK : LINK_W'(i + 1);
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                front_reg    <= front_next;
                back_reg     <= back_next;
                free_top_reg <= free_top_next;
                if (give)
                begin
                    free_link_reg[e_idx] <= free_top_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_tdata[KIND_W-1:0];
            in_word_reg <= s_tdata[KIND_W+WORD_W-1:KIND_W];
        end
        if (fire)
        begin
            out_word_reg   <= rd_word;
            out_status_reg <= rd_status;
            if (take)
            begin
                node_word_reg[n_idx] <= in_word_reg;
                node_next_reg[n_idx] <= nx_a_val;
                node_prev_reg[n_idx] <= pv_a_val;
            end
            if (nx_b_en)
            begin
                node_next_reg[nx_b_idx] <= nx_b_val;
            end
            if (pv_b_en)
            begin
                node_prev_reg[pv_b_idx] <= pv_b_val;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - STATUS_W){1'b0}}, out_status_reg, out_word_reg};

    `PLD_ASSERT_SAME(a_ends_agree, clk, rst_n, 1'b1,
        (front_reg < NULL_LINK) == (back_reg < NULL_LINK))
    `PLD_ASSERT_SAME(a_full_not_empty, clk, rst_n, !(free_top_reg < NULL_LINK),
        front_reg < NULL_LINK)
    `PLD_ASSERT_NEXT(a_first_push, clk, rst_n, fire && take && empty,
        (front_reg == back_reg) && (front_reg < NULL_LINK))
    `PLD_ASSERT_NEXT(a_pop_ok, clk, rst_n, fire && give,
        out_valid_reg && (out_status_reg == STATUS_OK) && (free_top_reg < NULL_LINK))

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
    import pld_pkg::*;

    localparam kind_t KIND_UNUSED_6 = 3'd6;
    localparam kind_t KIND_UNUSED_7 = 3'd7;
    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    HOLD_CYCLES   = 80;
    localparam int    DRAIN_CYCLES  = 12;
    localparam int    RANDOM_ITEMS  = 600;

    typedef struct {
        kind_t   kind;
        word_t   word;
        int      reps;
        bit      fixed;
        word_t   rd;
        status_t st;
    } table_row_t;

    typedef struct {
        kind_t   kind;
        word_t   word;
        bit      pause;
        bit      fixed;
        word_t   rd;
        status_t st;
    } request_t;

    typedef struct {
        word_t   rd;
        status_t st;
    } answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    word_t   pool_word [POOL_DEPTH];
    link_t   pool_next [POOL_DEPTH];
    link_t   pool_prev [POOL_DEPTH];
    link_t   free_next [POOL_DEPTH];
    link_t   head_link;
    link_t   tail_link;
    link_t   spare_link;

    request_t request_q[$];
    answer_t  pending_answers[$];
    answer_t  got_answer;
    answer_t  want_answer;
    int       error_count    = 0;
    int       items_accepted = 0;
    int       cycle_count    = 0;

    table_row_t directed_rows [18] = '{
        '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_PEEK_FRONT, 32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_PEEK_BACK,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_UNUSED_6,   32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_UNUSED_7,   32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_PUSH_FRONT, 32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_PUSH_BACK,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_PEEK_FRONT, 32'h0000_0000,  1, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
        '{KIND_PEEK_BACK,  32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
        '{KIND_PUSH_BACK,  32'h8000_0001, 16, 1'b1, 32'h0000_0000, STATUS_OK},
        '{KIND_PUSH_FRONT, 32'h1234_5678,  1, 1'b1, 32'h0000_0000, STATUS_FULL},
        '{KIND_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, STATUS_FULL},
        '{KIND_PEEK_BACK,  32'h0000_0000,  1, 1'b1, 32'h8000_0001, STATUS_OK},
        '{KIND_POP_FRONT,  32'h0000_0000, 16, 1'b1, 32'h8000_0001, STATUS_OK},
        '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b1, 32'h0000_0000, STATUS_EMPTY}
    };

    pooled_linked_deque_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_node(input link_t link);
        return link < link_t'(POOL_DEPTH);
    endfunction

    task automatic deque_clear();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_word[i] = '0;
            pool_next[i] = NULL_LINK;
            pool_prev[i] = NULL_LINK;
            free_next[i] = link_t'(i + 1);
        end
        head_link = NULL_LINK;
        tail_link = NULL_LINK;
        spare_link = '0;
    endtask

    task automatic deque_operate(input kind_t kind, input word_t word,
                                 output word_t rd, output status_t st);
        link_t n;
        rd = '0;
        st = STATUS_OK;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                n = spare_link;
                if (!is_node(n))
                    st = STATUS_FULL;
                else
                begin
                    spare_link = free_next[n];
                    pool_word[n] = word;
                    pool_next[n] = NULL_LINK;
                    pool_prev[n] = NULL_LINK;
                    if (!is_node(head_link))
                    begin
                        head_link = n;
                        tail_link = n;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        pool_next[n] = head_link;
                        pool_prev[head_link] = n;
                        head_link = n;
                    end
                    else
                    begin
                        pool_next[tail_link] = n;
                        pool_prev[n] = tail_link;
                        tail_link = n;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                n = (kind == KIND_POP_FRONT) ? head_link : tail_link;
                if (!is_node(n))
                    st = STATUS_EMPTY;
                else
                begin
                    rd = pool_word[n];
                    if (kind == KIND_POP_FRONT)
                    begin
                        head_link = pool_next[n];
                        if (is_node(head_link))
                            pool_prev[head_link] = NULL_LINK;
                        else
                            tail_link = NULL_LINK;
                    end
                    else
                    begin
                        tail_link = pool_prev[n];
                        if (is_node(tail_link))
                            pool_next[tail_link] = NULL_LINK;
                        else
                            head_link = NULL_LINK;
                    end
                    pool_word[n] = '0;
                    pool_next[n] = NULL_LINK;
                    pool_prev[n] = NULL_LINK;
                    free_next[n] = spare_link;
                    spare_link = n;
                end
            end
            KIND_PEEK_FRONT:
            begin
                if (is_node(head_link))
                    rd = pool_word[head_link];
                else
                    st = STATUS_EMPTY;
            end
            KIND_PEEK_BACK:
            begin
                if (is_node(tail_link))
                    rd = pool_word[tail_link];
                else
                    st = STATUS_EMPTY;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("testbench: mismatch in %s at cycle %0d: got %h, want %h",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input kind_t kind, input word_t word);
        request_t r;
        r = '{kind, word, 1'b0, 1'b0, '0, STATUS_OK};
        request_q.push_back(r);
    endtask

    task automatic queue_pause();
        request_t r;
        r = '{KIND_PEEK_FRONT, '0, 1'b1, 1'b0, '0, STATUS_OK};
        request_q.push_back(r);
    endtask

    task automatic build_requests();
        request_t r;
        int       made;
        int       count;
        int       pick;
        bit       paused;
        foreach (directed_rows[i])
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                r = '{directed_rows[i].kind, directed_rows[i].word, 1'b0,
                      directed_rows[i].fixed, directed_rows[i].rd, directed_rows[i].st};
                request_q.push_back(r);
            end
        queue_pause();
        made = 0;
        paused = 1'b0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                count = $urandom_range(4, 20);
                for (int k = 0; k < count; k++)
                    queue_request(kind_t'($urandom_range(0, 1)), pick_word());
                made += count;
                count = $urandom_range(4, 20);
                for (int k = 0; k < count; k++)
                    queue_request(kind_t'($urandom_range(2, 5)), pick_word());
                made += count;
            end
            else if (pick < 9)
            begin
                for (int k = 0; k < 20; k++)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8:
                            queue_request(kind_t'($urandom_range(0, 1)), pick_word());
                        9, 10, 11, 12, 13, 14, 15:
                            queue_request(kind_t'($urandom_range(2, 3)), pick_word());
                        16, 17, 18:
                            queue_request(kind_t'($urandom_range(4, 5)), pick_word());
                        default:
                            queue_request(kind_t'($urandom_range(6, 7)), pick_word());
                    endcase
                end
                made += 20;
            end
            else
            begin
                for (int k = 0; k < 5; k++)
                    queue_request(kind_t'($urandom_range(0, 7)), $urandom);
                made += 5;
            end
            if (!paused && made >= RANDOM_ITEMS / 2)
            begin
                queue_pause();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin : sender
        request_t r;
        answer_t  a;
        int       burst_left;
        int       gap;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        deque_clear();
        build_requests();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        burst_left = 0;
        while (request_q.size() != 0)
        begin
            r = request_q.pop_front();
            if (r.pause)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_answers.size() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0)
                    begin
                        @(negedge clk);
                        s_tvalid <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                @(negedge clk);
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({r.word, r.kind});
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                deque_operate(r.kind, r.word, a.rd, a.st);
                if (r.fixed)
                begin
                    a.rd = r.rd;
                    a.st = r.st;
                end
                pending_answers.push_back(a);
                items_accepted++;
                burst_left--;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : receiver
        int seg_left;
        int mode;
        int period;
        int phase;
        bit held_off;
        seg_left = 0;
        mode     = 0;
        period   = 1;
        phase    = 0;
        held_off = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && items_accepted >= 150)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    period   = $urandom_range(2, 4);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default:
                    begin
                        m_tready <= (phase % period == 0);
                        phase++;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_answer.rd = m_tdata[WORD_W-1:0];
            got_answer.st = m_tdata[WORD_W+STATUS_W-1:WORD_W];
            if (pending_answers.size() == 0)
                report_error("unexpected result", m_tdata[31:0], '0);
            else
            begin
                want_answer = pending_answers.pop_front();
                if (got_answer.rd !== want_answer.rd)
                    report_error("read_word", got_answer.rd, want_answer.rd);
                if (got_answer.st !== want_answer.st)
                    report_error("status", 32'(got_answer.st), 32'(want_answer.st));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
